[src/blep_pkg.sv]
// shared types and constants for the build error line parser
// no dependencies; imported by every module of the block
package blep_pkg;

    // parser phase within one diagnostic line
    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_LINE,
        PH_COLUMN,
        PH_SKIP,
        PH_MESSAGE,
        PH_INVALID
    } phase_t;

    // width of the reported position fields
    localparam int LEN_W = 11;
    // width of the decimal accumulators
    localparam int NUM_W = 32;

    // character codes
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // decimal radix and saturation value
    localparam logic [3:0]       RADIX = 4'd10;
    localparam logic [NUM_W-1:0] SAT   = {NUM_W{1'b1}};

    // command codes
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_EOL  = 1'b1;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

[src/blep_accum.sv]
// saturating decimal accumulate: acc * 10 + digit, sticks at all ones
// depends on blep_pkg
module blep_accum
    import blep_pkg::*;
(
    input  logic [NUM_W-1:0] acc,
    input  logic [7:0]       ch,
    output logic [NUM_W-1:0] result
);

    logic [3:0]       digit;
    logic [NUM_W+3:0] sum;

    // times ten as shift-and-add, plus the digit value
    always_comb
    begin
        digit = 4'(ch - CH_ZERO);
        sum   = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{NUM_W{1'b0}}, digit};
        if (sum[NUM_W+3:NUM_W] != 4'd0)
        begin
            result = SAT;
        end
        else
        begin
            result = sum[NUM_W-1:0];
        end
    end

endmodule

[src/build_error_line_parser_top.sv]
// top level of the build error line parser: input stage, parser state, result register
// depends on blep_pkg and blep_accum
//
// Takes a compiler diagnostic line one character per transaction (cmd 0) and
// closes it with an end-of-line transaction (cmd 1), which yields one result:
// validity, name length, line and column numbers, and message start and
// length as character positions from 0. Characters beyond MAX_LINE are
// ignored. Throughput is one transaction per cycle while no end-of-line
// transaction waits. The result of an end-of-line transaction passes the
// input register and then the result register; the parser logic after the
// input register uses the shared saturating multiply-by-ten accumulator.
// Character transactions move on while a result waits; an end-of-line
// transaction waits in the input register until the result register is
// free, and the input is held off for that time.
module build_error_line_parser_top
    import blep_pkg::*;
#(
    parameter int MAX_LINE = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             cmd,
    input  logic [7:0]       ch,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             valid_res,
    output logic [LEN_W-1:0] name_length,
    output logic [NUM_W-1:0] line_number,
    output logic [NUM_W-1:0] column_number,
    output logic [LEN_W-1:0] message_start,
    output logic [LEN_W-1:0] message_length
);

    localparam int PW = $clog2(MAX_LINE + 1);

    // input stage
    logic       s1_valid_reg, s1_valid_next;
    logic       s1_cmd_reg;
    logic [7:0] s1_ch_reg;
    logic       s1_go;

    // parser state
    phase_t           phase_reg, phase_next;
    logic [PW-1:0]    position_reg, position_next;
    logic             prev_colon_reg, prev_colon_next;
    logic [PW-1:0]    name_end_reg, name_end_next;
    logic [NUM_W-1:0] line_reg, line_next;
    logic [NUM_W-1:0] column_reg, column_next;
    logic [PW-1:0]    msg_begin_reg, msg_begin_next;

    // result register
    logic             out_valid_reg, out_valid_next;
    logic             valid_res_reg;
    logic [LEN_W-1:0] name_length_reg;
    logic [NUM_W-1:0] line_number_reg;
    logic [NUM_W-1:0] column_number_reg;
    logic [LEN_W-1:0] message_start_reg;
    logic [LEN_W-1:0] message_length_reg;

    logic [NUM_W-1:0] acc_in;
    logic [NUM_W-1:0] acc_out;
    logic             in_range;
    logic [PW-1:0]    msg_len;
    logic [LEN_W-1:0] name_end_w;
    logic [LEN_W-1:0] msg_begin_w;
    logic [LEN_W-1:0] msg_len_w;
    logic             line_ok;

    // handshake: a character always moves on, an end of line needs a free result slot
    assign s1_go    = s1_valid_reg && ((s1_cmd_reg == CMD_CHAR) || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_cmd_reg <= cmd;
            s1_ch_reg  <= ch;
        end
    end

    // shared accumulator operand: fresh line number, running line or column
    always_comb
    begin
        case (phase_reg)
            PH_LINE:   acc_in = line_reg;
            PH_COLUMN: acc_in = column_reg;
            default:   acc_in = '0;
        endcase
    end

    blep_accum u_accum (
        .acc    (acc_in),
        .ch     (s1_ch_reg),
        .result (acc_out)
    );

    assign in_range = (position_reg < PW'(MAX_LINE));

    // next state of the parser
    always_comb
    begin
        phase_next      = phase_reg;
        position_next   = position_reg;
        prev_colon_next = prev_colon_reg;
        name_end_next   = name_end_reg;
        line_next       = line_reg;
        column_next     = column_reg;
        msg_begin_next  = msg_begin_reg;
        if (s1_go)
        begin
            if (s1_cmd_reg == CMD_EOL)
            begin
                phase_next      = PH_SEARCH;
                position_next   = '0;
                prev_colon_next = 1'b0;
                name_end_next   = '0;
                line_next       = '0;
                column_next     = '0;
                msg_begin_next  = '0;
            end
            else if (in_range)
            begin
                case (phase_reg)
                    PH_SEARCH:
                    begin
                        if (prev_colon_reg && is_digit(s1_ch_reg))
                        begin
                            if (position_reg == PW'(1))
                            begin
                                phase_next = PH_INVALID;
                            end
                            else
                            begin
                                name_end_next = position_reg - PW'(1);
                                line_next     = acc_out;
                                phase_next    = PH_LINE;
                            end
                        end
                        prev_colon_next = (s1_ch_reg == CH_COLON);
                    end
                    PH_LINE, PH_COLUMN, PH_SKIP:
                    begin
                        if (phase_reg == PH_LINE && is_digit(s1_ch_reg))
                        begin
                            line_next = acc_out;
                        end
                        else if (phase_reg == PH_COLUMN && is_digit(s1_ch_reg))
                        begin
                            column_next = acc_out;
                        end
                        else if (phase_reg == PH_LINE && s1_ch_reg == CH_COLON)
                        begin
                            phase_next = PH_COLUMN;
                        end
                        else if (s1_ch_reg == CH_COLON || s1_ch_reg == CH_SPACE)
                        begin
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            msg_begin_next = position_reg;
                            phase_next     = PH_MESSAGE;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
                position_next = position_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SEARCH;
            position_reg   <= '0;
            prev_colon_reg <= 1'b0;
            name_end_reg   <= '0;
            line_reg       <= '0;
            column_reg     <= '0;
            msg_begin_reg  <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            position_reg   <= position_next;
            prev_colon_reg <= prev_colon_next;
            name_end_reg   <= name_end_next;
            line_reg       <= line_next;
            column_reg     <= column_next;
            msg_begin_reg  <= msg_begin_next;
        end
    end

    // positions fitted to the reported field width
    assign msg_len = position_reg - msg_begin_reg;

    generate
        if (PW >= LEN_W)
        begin : g_trunc
            assign name_end_w  = name_end_reg[LEN_W-1:0];
            assign msg_begin_w = msg_begin_reg[LEN_W-1:0];
            assign msg_len_w   = msg_len[LEN_W-1:0];
        end
        else
        begin : g_extend
            assign name_end_w  = {{(LEN_W-PW){1'b0}}, name_end_reg};
            assign msg_begin_w = {{(LEN_W-PW){1'b0}}, msg_begin_reg};
            assign msg_len_w   = {{(LEN_W-PW){1'b0}}, msg_len};
        end
    endgenerate

    assign line_ok = (phase_reg == PH_LINE || phase_reg == PH_COLUMN ||
                      phase_reg == PH_SKIP || phase_reg == PH_MESSAGE) &&
                     (line_reg != '0);

    // result valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_go && s1_cmd_reg == CMD_EOL)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, all zero for an invalid line
    always_ff @(posedge clk)
    begin
        if (s1_go && s1_cmd_reg == CMD_EOL)
        begin
            valid_res_reg      <= line_ok;
            name_length_reg    <= line_ok ? name_end_w : '0;
            line_number_reg    <= line_ok ? line_reg : '0;
            column_number_reg  <= line_ok ? column_reg : '0;
            message_start_reg  <= (line_ok && phase_reg == PH_MESSAGE) ? msg_begin_w : '0;
            message_length_reg <= (line_ok && phase_reg == PH_MESSAGE) ? msg_len_w : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign valid_res      = valid_res_reg;
    assign name_length    = name_length_reg;
    assign line_number    = line_number_reg;
    assign column_number  = column_number_reg;
    assign message_start  = message_start_reg;
    assign message_length = message_length_reg;

    // checks on the parser state and results
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        position_reg <= PW'(MAX_LINE))
        else $error("position beyond line limit");

    a_search_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SEARCH |-> line_reg == '0 && column_reg == '0)
        else $error("numbers accumulated before name end");

    a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && s1_cmd_reg == CMD_EOL |=> position_reg == '0 && phase_reg == PH_SEARCH)
        else $error("state not cleared after end of line");

    a_valid_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> line_number != '0)
        else $error("valid result with zero line number");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> name_length == '0 && line_number == '0 &&
        column_number == '0 && message_start == '0 && message_length == '0)
        else $error("invalid result carries non-zero fields");

endmodule
